[sv/cmmt_pkg.sv]
// Package for the counted multiset max tracker: widths, defaults, payload types, states.
`timescale 1ns / 1ps

package cmmt_pkg;

	// Fixed field widths
	localparam int VALUE_W = 10;

	// Default configuration
	localparam int VALUE_RANGE_DEF = 1024;
	localparam int BUCKET_SIZE_DEF = 32;
	localparam int COUNT_BITS_DEF  = 16;

	// Opcodes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [VALUE_W-1:0] max_value;
		logic               empty_res;
		logic               count_error;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_UPD_CNT,
		ST_UPD_TOT,
		ST_BSCAN,
		ST_VSTART,
		ST_VSCAN,
		ST_DONE
	} state_t;

endpackage

[sv/counted_multiset_max_tracker.sv]
// Counted multiset max tracker: per-value counts, per-bucket totals, sequenced max scan.
// Sequence: a read, the count and total updates, a bucket scan from the top bucket down,
//   the value scan start, a value scan down the found bucket, and the result load (32 buckets of 32 at the defaults).
// Throughput: one item at a time; the scan reads one memory word per cycle through
//   the bucket total and count memory read ports, and one shared adder steps the value addresses.
// Reset: control clears at once; a clearing pass over every value address then zeroes both
//   memories, during which cmd_stall stays high.
`timescale 1ns / 1ps

module counted_multiset_max_tracker #(
	parameter int VALUE_RANGE = cmmt_pkg::VALUE_RANGE_DEF,
	parameter int BUCKET_SIZE = cmmt_pkg::BUCKET_SIZE_DEF,
	parameter int COUNT_BITS  = cmmt_pkg::COUNT_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  cmmt_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output cmmt_pkg::rsp_t rsp
);

	localparam int VW      = cmmt_pkg::VALUE_W;
	localparam int NUM_B   = (VALUE_RANGE + BUCKET_SIZE - 1) / BUCKET_SIZE;
	localparam int VA_W    = $clog2(VALUE_RANGE);
	localparam int BA_W    = (NUM_B > 1) ? $clog2(NUM_B) : 1;
	localparam int L       = $clog2(BUCKET_SIZE);
	localparam int TOT_W   = COUNT_BITS + L;
	localparam int ADR_W   = $clog2(VALUE_RANGE + BUCKET_SIZE) + 1;
	localparam int AW      = (TOT_W > ADR_W) ? TOT_W : ADR_W;
	// Reciprocal for the bucket index: exact for every VW-bit value
	localparam int SH      = VW + L;
	localparam int M_W     = VW + 2;
	localparam int P_W     = VW + M_W;
	localparam longint unsigned MULT_L =
		((64'd1 << SH) + 64'(BUCKET_SIZE) - 64'd1) / 64'(BUCKET_SIZE);
	localparam logic [M_W-1:0]   MULT     = M_W'(MULT_L);
	localparam logic [AW-1:0]    TOP_BASE = AW'((NUM_B - 1) * BUCKET_SIZE);
	localparam logic [AW-1:0]    LAST_V   = AW'(VALUE_RANGE - 1);
	localparam logic [AW-1:0]    BS_A     = AW'(BUCKET_SIZE);
	localparam logic [AW-1:0]    BS_M1    = AW'(BUCKET_SIZE - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

	// Memories
	logic [COUNT_BITS-1:0] cnt_mem [VALUE_RANGE];
	logic [TOT_W-1:0]      tot_mem [NUM_B];

	cmmt_pkg::state_t state_q, state_d;

	// Control registers
	logic [VA_W-1:0] clr_q;
	logic            pend_q;
	logic            iss_done_q;
	logic            rsp_valid_q;

	// Payload registers
	logic            op_q;
	logic [VW-1:0]   val_q;
	logic [P_W-1:0]  prod_q;
	logic            err_q;
	logic [BA_W-1:0] bidx_q;
	logic [AW-1:0]   vbase_q;
	logic [AW-1:0]   tag_base_q;
	logic            tag_last_q;
	logic [AW-1:0]   fbase_q;
	logic [AW-1:0]   vaddr_q;
	logic [AW-1:0]   vtag_q;
	logic [VW-1:0]   res_max_q;
	logic            res_empty_q;
	cmmt_pkg::rsp_t  rsp_q;
	logic [COUNT_BITS-1:0] cnt_rdata_q;
	logic [TOT_W-1:0]      tot_rdata_q;

	// Combinational control
	logic                  accept;
	logic                  in_range;
	logic                  res_ld;
	logic                  cnt_err;
	logic                  tot_hit;
	logic                  cnt_hit;
	logic [BA_W-1:0]       bkt;
	logic [VA_W-1:0]       vaddr_cur;
	logic                  cnt_we;
	logic [VA_W-1:0]       cnt_waddr;
	logic [COUNT_BITS-1:0] cnt_wdata;
	logic [VA_W-1:0]       cnt_raddr;
	logic                  tot_we;
	logic [BA_W-1:0]       tot_waddr;
	logic [TOT_W-1:0]      tot_wdata;
	logic [BA_W-1:0]       tot_raddr;
	logic [AW-1:0]         add_a;
	logic [AW-1:0]         add_b;
	logic                  add_sub;
	logic [AW-1:0]         add_y;
	logic [AW-1:0]         vstart;

	assign accept    = cmd_valid && !cmd_stall;
	assign in_range  = 32'(cmd.value) < VALUE_RANGE;
	assign bkt       = BA_W'(prod_q >> SH);
	assign vaddr_cur = VA_W'(val_q);
	assign cnt_err   = (op_q == cmmt_pkg::OP_REMOVE) ? (cnt_rdata_q == '0)
	                                                 : (cnt_rdata_q == COUNT_FULL);
	assign tot_hit   = tot_rdata_q != '0;
	assign cnt_hit   = cnt_rdata_q != '0;

	// Shared adder
	assign add_y  = add_sub ? (add_a - add_b) : (add_a + add_b);
	assign vstart = (add_y > LAST_V) ? LAST_V : add_y;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmmt_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory ports and adder operands
	always_comb begin
		state_d   = state_q;
		cmd_stall = 1'b1;
		res_ld    = 1'b0;
		cnt_we    = 1'b0;
		cnt_waddr = clr_q;
		cnt_wdata = '0;
		cnt_raddr = vaddr_cur;
		tot_we    = 1'b0;
		tot_waddr = BA_W'(clr_q);
		tot_wdata = '0;
		tot_raddr = bkt;
		add_a     = vaddr_q;
		add_b     = AW'(1);
		add_sub   = 1'b1;
		unique case (state_q)
			cmmt_pkg::ST_CLEAR: begin
				cnt_we = 1'b1;
				tot_we = 32'(clr_q) < NUM_B;
				if (clr_q == VA_W'(VALUE_RANGE - 1)) begin
					state_d = cmmt_pkg::ST_IDLE;
				end
			end
			cmmt_pkg::ST_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					state_d = in_range ? cmmt_pkg::ST_READ : cmmt_pkg::ST_BSCAN;
				end
			end
			cmmt_pkg::ST_READ: begin
				state_d = cmmt_pkg::ST_UPD_CNT;
			end
			cmmt_pkg::ST_UPD_CNT: begin
				add_a     = AW'(cnt_rdata_q);
				add_sub   = op_q;
				cnt_we    = !cnt_err;
				cnt_waddr = vaddr_cur;
				cnt_wdata = COUNT_BITS'(add_y);
				state_d   = cmmt_pkg::ST_UPD_TOT;
			end
			cmmt_pkg::ST_UPD_TOT: begin
				add_a     = AW'(tot_rdata_q);
				add_sub   = op_q;
				tot_we    = !err_q;
				tot_waddr = bkt;
				tot_wdata = TOT_W'(add_y);
				state_d   = cmmt_pkg::ST_BSCAN;
			end
			cmmt_pkg::ST_BSCAN: begin
				add_a     = vbase_q;
				add_b     = BS_A;
				tot_raddr = bidx_q;
				if (pend_q && tot_hit) begin
					state_d = cmmt_pkg::ST_VSTART;
				end else if (pend_q && tag_last_q) begin
					state_d = cmmt_pkg::ST_DONE;
				end
			end
			cmmt_pkg::ST_VSTART: begin
				add_a   = fbase_q;
				add_b   = BS_M1;
				add_sub = 1'b0;
				state_d = cmmt_pkg::ST_VSCAN;
			end
			cmmt_pkg::ST_VSCAN: begin
				cnt_raddr = VA_W'(vaddr_q);
				if (pend_q && (cnt_hit || vtag_q == fbase_q)) begin
					state_d = cmmt_pkg::ST_DONE;
				end
			end
			cmmt_pkg::ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					res_ld  = 1'b1;
					state_d = cmmt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cmmt_pkg::ST_CLEAR;
			end
		endcase
	end

	// Count memory
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		cnt_rdata_q <= cnt_mem[cnt_raddr];
	end

	// Bucket total memory
	always_ff @(posedge clk) begin
		if (tot_we) begin
			tot_mem[tot_waddr] <= tot_wdata;
		end
		tot_rdata_q <= tot_mem[tot_raddr];
	end

	// Sequencer control: clear sweep, scan read tracking, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			pend_q      <= 1'b0;
			iss_done_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == cmmt_pkg::ST_CLEAR) begin
				clr_q <= clr_q + VA_W'(1);
			end
			if (accept || state_q == cmmt_pkg::ST_VSTART) begin
				pend_q     <= 1'b0;
				iss_done_q <= 1'b0;
			end else if (state_q == cmmt_pkg::ST_BSCAN) begin
				pend_q <= !iss_done_q;
				if (bidx_q == '0) begin
					iss_done_q <= 1'b1;
				end
			end else if (state_q == cmmt_pkg::ST_VSCAN) begin
				pend_q <= !iss_done_q;
				if (vaddr_q == fbase_q) begin
					iss_done_q <= 1'b1;
				end
			end
			if (res_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= cmd.opcode;
			val_q   <= cmd.value;
			prod_q  <= P_W'(cmd.value) * P_W'(MULT);
			err_q   <= 1'b0;
			bidx_q  <= BA_W'(NUM_B - 1);
			vbase_q <= TOP_BASE;
		end
		if (state_q == cmmt_pkg::ST_UPD_CNT) begin
			err_q <= cnt_err;
		end
		// Bucket scan: issue one total read per cycle, check the one in flight
		if (state_q == cmmt_pkg::ST_BSCAN) begin
			if (!iss_done_q) begin
				tag_base_q <= vbase_q;
				tag_last_q <= bidx_q == '0;
				vbase_q    <= add_y;
				bidx_q     <= bidx_q - BA_W'(1);
			end
			if (pend_q && tot_hit) begin
				fbase_q <= tag_base_q;
			end else if (pend_q && tag_last_q) begin
				res_max_q   <= '0;
				res_empty_q <= 1'b1;
			end
		end
		// Start value scan at the bucket top, padding clipped off
		if (state_q == cmmt_pkg::ST_VSTART) begin
			vaddr_q <= vstart;
		end
		// Value scan: issue one count read per cycle, check the one in flight
		if (state_q == cmmt_pkg::ST_VSCAN) begin
			if (!iss_done_q) begin
				vtag_q  <= vaddr_q;
				vaddr_q <= add_y;
			end
			if (pend_q && cnt_hit) begin
				res_max_q   <= VW'(vtag_q);
				res_empty_q <= 1'b0;
			end else if (pend_q && vtag_q == fbase_q) begin
				res_max_q   <= '0;
				res_empty_q <= 1'b1;
			end
		end
		if (res_ld) begin
			rsp_q.max_value   <= res_max_q;
			rsp_q.empty_res   <= res_empty_q;
			rsp_q.count_error <= err_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> cmd_stall)
		else $error("input taken again right after a transfer");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!rsp.empty_res || rsp.max_value == '0))
		else $error("empty result with nonzero max");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cmmt_pkg::ST_BSCAN || state_q == cmmt_pkg::ST_VSCAN)
		|-> (!cnt_we && !tot_we))
		else $error("memory write during max scan");

endmodule
